[hw/rtl/tppi_pkg.sv]
// Shared types, constants and control words for the timed polyline path interpolator.
`default_nettype none
package tppi_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int COORD_W = 32;
    localparam int TIME_W  = 31;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 66;
    localparam int SEG_W   = 33;
    localparam int ACC_W   = 48;
    localparam int SIDX_W  = 6;
    localparam int TOT_W   = 7;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_TIME  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_DWELL = 3'd4;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [TIME_W-1:0]         dwell_delay;
        logic [TIME_W-1:0]         time_value;
    } tppi_in_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic [SIDX_W-1:0]         segment_index;
        logic [TIME_W-1:0]         current_time;
        logic [TOT_W-1:0]          node_total;
    } tppi_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TIME_W-1:0]         dwell;
    } tppi_node_t;

    typedef struct packed {
        logic cfg_load;
        logic item_load;
        logic exec_time;
        logic node_wr;
        logic addr_prev;
        logic diff_load;
        logic sq_mul;
        logic sq_acc;
        logic sqrt_start;
        logic seg_commit;
        logic ts_init;
        logic ts_cum;
        logic ts_write;
        logic q_init;
        logic q_check;
        logic addr_seg;
        logic lat_a;
        logic lat_b;
        logic calc;
        logic lerp_start;
        logic lerp_store;
        logic out_load;
    } tppi_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       n_zero;
        logic       n_one;
        logic       pl_zero;
        logic       sq_last;
        logic       sqrt_done;
        logic       md_done;
        logic       ts_last;
        logic       scan_last;
        logic       lerp;
        logic       axis_last;
        logic       out_free;
    } tppi_sts_t;

endpackage
`default_nettype wire

[hw/rtl/tppi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tppi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/tppi_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits per cycle.
`default_nettype none
module tppi_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tppi_pkg::SQ_W-1:0]    radicand,
    output logic                              done,
    output logic      [tppi_pkg::SEG_W-1:0]   root
);
    import tppi_pkg::*;

    localparam int ITER  = SQ_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam int REM_W = SEG_W + 2;

    logic [SQ_W-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SEG_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rem_sub;
    logic             ge;

    always_comb begin
        rem2    = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem2 >= trial;
        rem_sub = ge ? rem2 - trial : rem2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ITER);
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
                rem_reg  <= rem_sub[REM_W-1:0];
                root_reg <= {root_reg[SEG_W-2:0], ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

[hw/rtl/tppi_muldiv.sv]
// Serial floor(a * b / d) for b <= d, one multiplier bit per cycle.
`default_nettype none
module tppi_muldiv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [tppi_pkg::MAG_W-1:0]  a,
    input  wire logic [tppi_pkg::ACC_W-1:0]  b,
    input  wire logic [tppi_pkg::ACC_W-1:0]  d,
    output logic                             done,
    output logic      [tppi_pkg::MAG_W-1:0]  q
);
    import tppi_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int V_W   = ACC_W + 2;

    logic [MAG_W-1:0] a_reg;
    logic [ACC_W-1:0] b_reg;
    logic [ACC_W-1:0] d_reg;
    logic [ACC_W-1:0] r_reg;
    logic [MAG_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [V_W-1:0]   v;
    logic [V_W-1:0]   d1;
    logic [V_W-1:0]   d2;
    logic [V_W-1:0]   r_new;
    logic             ge1;
    logic             ge2;
    logic [MAG_W-1:0] q_next;

    always_comb begin
        v      = {1'b0, r_reg, 1'b0} + (a_reg[MAG_W-1] ? {2'b00, b_reg} : V_W'(0));
        d1     = {2'b00, d_reg};
        d2     = {1'b0, d_reg, 1'b0};
        ge2    = v >= d2;
        ge1    = v >= d1;
        r_new  = ge2 ? v - d2 : (ge1 ? v - d1 : v);
        q_next = {q_reg[MAG_W-2:0], 1'b0}
               + (ge2 ? MAG_W'(2) : (ge1 ? MAG_W'(1) : MAG_W'(0)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
                a_reg    <= a;
                b_reg    <= b;
                d_reg    <= d;
                r_reg    <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                a_reg   <= {a_reg[MAG_W-2:0], 1'b0};
                r_reg   <= r_new[ACC_W-1:0];
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

[hw/rtl/tppi_datapath.sv]
// Datapath: node tables, path sums, square root, mul-divide and result register.
`default_nettype none
module tppi_datapath #(
    parameter int MAX_NODES = tppi_pkg::MAX_NODES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire tppi_pkg::tppi_cmd_t          cmd,
    output tppi_pkg::tppi_sts_t               sts,
    input  wire tppi_pkg::tppi_in_t           s_data,
    input  wire logic [tppi_pkg::TIME_W-1:0]  cfg_data,
    input  wire logic                         m_ready,
    output logic                              m_valid,
    output tppi_pkg::tppi_out_t               m_data
);
    import tppi_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int NODE_W = $bits(tppi_node_t);

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] p,
                                                  input logic signed [COORD_W-1:0] r);
        logic signed [COORD_W:0] diff;
        logic        [COORD_W:0] mag;
        diff = {p[COORD_W-1], p} - {r[COORD_W-1], r};
        mag  = diff[COORD_W] ? -diff : diff;
        return mag[MAG_W-1:0];
    endfunction

    tppi_in_t          in_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [ACC_W-1:0]  pl_reg;
    logic [ACC_W-1:0]  dsum_reg;
    logic [TIME_W-1:0] now_reg;
    logic              over_reg;
    logic [2:0]        rej_reg;
    logic [IDX_W-1:0]  addr_reg;

    logic [MAG_W-1:0]   d_reg [3];
    logic [1:0]         k_reg;
    logic [2*MAG_W-1:0] prod_reg;
    logic [SQ_W-1:0]    acc_reg;

    logic [TIME_W-1:0] travel_reg;
    logic [ACC_W-1:0]  cum_reg;
    logic [ACC_W-1:0]  before_reg;
    logic [TIME_W-1:0] dw_reg;

    logic [IDX_W-1:0]  seg_reg;
    tppi_node_t        a_reg;
    tppi_node_t        b_reg;
    logic [TIME_W-1:0] ts_a_reg;
    logic [TIME_W-1:0] ts_b_reg;
    logic [TIME_W-1:0] num_reg;
    logic [TIME_W-1:0] den_reg;
    logic              lerp_reg;
    logic [1:0]        axis_reg;
    logic signed [COORD_W-1:0] pos_reg [3];

    tppi_out_t         out_reg;
    logic              m_valid_reg;

    tppi_node_t        node_rd;
    logic [NODE_W-1:0] node_rd_raw;
    logic [SEG_W-1:0]  seg_rd;
    logic [TIME_W-1:0] ts_rd;
    logic [SEG_W-1:0]  root;
    logic              sqrt_done;
    logic [MAG_W-1:0]  md_q;
    logic              md_done;

    tppi_node_t        node_wr_data;
    logic [SEG_W-1:0]  seg_val;
    logic [ACC_W-1:0]  cum_next;
    logic [MAG_W-1:0]  part;
    logic [ACC_W:0]    ts_sum;
    logic [TIME_W-1:0] ts_val;
    logic [TIME_W-1:0] off;
    logic [TIME_W-1:0] num_c;
    logic signed [TIME_W+1:0] den_c;
    logic signed [COORD_W-1:0] ax_a;
    logic signed [COORD_W-1:0] ax_b;
    logic [MAG_W-1:0]  mag;
    logic              md_start;
    logic [MAG_W-1:0]  md_a;
    logic [ACC_W-1:0]  md_b;
    logic [ACC_W-1:0]  md_d;
    logic [TIME_W:0]   add_sum;
    tppi_out_t         out_next;

    assign node_rd = tppi_node_t'(node_rd_raw);

    always_comb begin
        node_wr_data.x     = in_reg.point_x;
        node_wr_data.y     = in_reg.point_y;
        node_wr_data.z     = in_reg.point_z;
        node_wr_data.dwell = in_reg.dwell_delay;
    end

    tppi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk    (aclk),
        .wr_en   (cmd.node_wr),
        .wr_addr (IDX_W'(n_reg)),
        .wr_data (node_wr_data),
        .rd_addr (addr_reg),
        .rd_data (node_rd_raw)
    );

    tppi_ram #(.WIDTH(SEG_W), .DEPTH(MAX_NODES)) u_seg_ram (
        .aclk    (aclk),
        .wr_en   (cmd.seg_commit),
        .wr_addr (IDX_W'(n_reg)),
        .wr_data (seg_val),
        .rd_addr (addr_reg),
        .rd_data (seg_rd)
    );

    tppi_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_ts_ram (
        .aclk    (aclk),
        .wr_en   (cmd.ts_write),
        .wr_addr (addr_reg),
        .wr_data (ts_val),
        .rd_addr (addr_reg),
        .rd_data (ts_rd)
    );

    tppi_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb begin
        seg_val  = (n_reg == '0) ? '0 : root;
        cum_next = cum_reg + ACC_W'(seg_rd);
        part     = (pl_reg == '0) ? '0 : md_q;
        ts_sum   = (ACC_W+1)'(part) + (ACC_W+1)'(before_reg);
        ts_val   = (ts_sum > (ACC_W+1)'(TIME_MAX)) ? TIME_MAX : ts_sum[TIME_W-1:0];
        add_sum  = (TIME_W+1)'(now_reg) + (TIME_W+1)'(in_reg.time_value);

        off   = (now_reg >= ts_a_reg) ? now_reg - ts_a_reg : '0;
        num_c = off - a_reg.dwell;
        den_c = $signed({2'b00, ts_b_reg}) - $signed({2'b00, ts_a_reg})
              - $signed({2'b00, a_reg.dwell});

        case (axis_reg)
            2'd0: begin
                ax_a = a_reg.x;
                ax_b = b_reg.x;
            end
            2'd1: begin
                ax_a = a_reg.y;
                ax_b = b_reg.y;
            end
            default: begin
                ax_a = a_reg.z;
                ax_b = b_reg.z;
            end
        endcase
        mag = abs_diff(ax_b, ax_a);

        md_start = cmd.lerp_start | (cmd.ts_cum & (pl_reg != '0));
        md_a     = cmd.lerp_start ? mag : MAG_W'(travel_reg);
        md_b     = cmd.lerp_start ? ACC_W'(num_reg) : cum_next;
        md_d     = cmd.lerp_start ? ACC_W'(den_reg) : pl_reg;
    end

    tppi_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (md_a),
        .b       (md_b),
        .d       (md_d),
        .done    (md_done),
        .q       (md_q)
    );

    // path state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg  <= '0;
            n_reg    <= '0;
            pl_reg   <= '0;
            dsum_reg <= '0;
            now_reg  <= '0;
            over_reg <= 1'b0;
            rej_reg  <= ST_OK;
        end else begin
            if (cmd.cfg_load) begin
                dur_reg <= cfg_data;
            end
            if (cmd.exec_time) begin
                rej_reg <= ST_OK;
                case (in_reg.operation)
                    OP_APPEND: begin
                        if (n_reg == CNT_W'(MAX_NODES)) begin
                            rej_reg <= ST_FULL;
                        end
                    end
                    OP_SET: begin
                        if (in_reg.time_value > dur_reg) begin
                            rej_reg <= ST_TIME;
                        end else begin
                            now_reg <= in_reg.time_value;
                        end
                    end
                    OP_ADD: begin
                        if (add_sum <= (TIME_W+1)'(dur_reg)) begin
                            now_reg <= add_sum[TIME_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.seg_commit) begin
                pl_reg   <= pl_reg + ACC_W'(seg_val);
                dsum_reg <= dsum_reg + ACC_W'(in_reg.dwell_delay);
                n_reg    <= n_reg + CNT_W'(1);
            end
            if (cmd.ts_init) begin
                over_reg <= dsum_reg > ACC_W'(dur_reg);
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            in_reg <= s_data;
        end
        if (cmd.addr_prev) begin
            addr_reg <= IDX_W'(n_reg - CNT_W'(1));
        end
        if (cmd.diff_load) begin
            d_reg[0] <= abs_diff(in_reg.point_x, node_rd.x);
            d_reg[1] <= abs_diff(in_reg.point_y, node_rd.y);
            d_reg[2] <= abs_diff(in_reg.point_z, node_rd.z);
            k_reg    <= 2'd0;
            acc_reg  <= '0;
        end
        if (cmd.sq_mul) begin
            prod_reg <= d_reg[k_reg] * d_reg[k_reg];
        end
        if (cmd.sq_acc) begin
            acc_reg <= acc_reg + SQ_W'(prod_reg);
            k_reg   <= k_reg + 2'd1;
        end
        if (cmd.ts_init) begin
            travel_reg <= (dsum_reg > ACC_W'(dur_reg)) ? '0
                        : dur_reg - dsum_reg[TIME_W-1:0];
            cum_reg    <= '0;
            before_reg <= '0;
            addr_reg   <= '0;
        end
        if (cmd.ts_cum) begin
            cum_reg <= cum_next;
            dw_reg  <= node_rd.dwell;
        end
        if (cmd.ts_write) begin
            before_reg <= before_reg + ACC_W'(dw_reg);
            addr_reg   <= addr_reg + IDX_W'(1);
        end
        if (cmd.q_init) begin
            seg_reg  <= '0;
            addr_reg <= '0;
        end
        if (cmd.q_check) begin
            if (ts_rd <= now_reg) begin
                seg_reg <= addr_reg;
            end
            addr_reg <= addr_reg + IDX_W'(1);
        end
        if (cmd.addr_seg) begin
            addr_reg <= seg_reg;
        end
        if (cmd.lat_a) begin
            a_reg      <= node_rd;
            ts_a_reg   <= ts_rd;
            pos_reg[0] <= node_rd.x;
            pos_reg[1] <= node_rd.y;
            pos_reg[2] <= node_rd.z;
            addr_reg   <= seg_reg + IDX_W'(1);
        end
        if (cmd.lat_b) begin
            b_reg    <= node_rd;
            ts_b_reg <= ts_rd;
        end
        if (cmd.calc) begin
            lerp_reg <= 1'b0;
            axis_reg <= 2'd0;
            num_reg  <= num_c;
            den_reg  <= den_c[TIME_W-1:0];
            if (off >= a_reg.dwell) begin
                if (den_c <= 0 || $signed({3'b000, num_c}) >= den_c) begin
                    pos_reg[0] <= b_reg.x;
                    pos_reg[1] <= b_reg.y;
                    pos_reg[2] <= b_reg.z;
                end else begin
                    lerp_reg <= 1'b1;
                end
            end
        end
        if (cmd.lerp_store) begin
            pos_reg[axis_reg] <= (ax_b >= ax_a) ? ax_a + $signed(md_q) : ax_a - $signed(md_q);
            axis_reg          <= axis_reg + 2'd1;
        end
    end

    // result word
    always_comb begin
        out_next.status = (rej_reg != ST_OK) ? rej_reg
                        : (n_reg == '0) ? ST_EMPTY
                        : over_reg ? ST_DWELL : ST_OK;
        if (n_reg == '0) begin
            out_next.pos_x    = '0;
            out_next.pos_y    = '0;
            out_next.pos_z    = '0;
            out_next.target_x = '0;
            out_next.target_y = '0;
            out_next.target_z = '0;
        end else if (n_reg == CNT_W'(1)) begin
            out_next.pos_x    = a_reg.x;
            out_next.pos_y    = a_reg.y;
            out_next.pos_z    = a_reg.z;
            out_next.target_x = a_reg.x;
            out_next.target_y = a_reg.y;
            out_next.target_z = a_reg.z;
        end else begin
            out_next.pos_x    = pos_reg[0];
            out_next.pos_y    = pos_reg[1];
            out_next.pos_z    = pos_reg[2];
            out_next.target_x = b_reg.x;
            out_next.target_y = b_reg.y;
            out_next.target_z = b_reg.z;
        end
        out_next.segment_index = SIDX_W'(seg_reg);
        out_next.current_time  = now_reg;
        out_next.node_total    = TOT_W'(n_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        sts.op        = in_reg.operation;
        sts.full      = n_reg == CNT_W'(MAX_NODES);
        sts.n_zero    = n_reg == '0;
        sts.n_one     = n_reg == CNT_W'(1);
        sts.pl_zero   = pl_reg == '0;
        sts.sq_last   = k_reg == 2'd2;
        sts.sqrt_done = sqrt_done;
        sts.md_done   = md_done;
        sts.ts_last   = (CNT_W'(addr_reg) + CNT_W'(1)) == n_reg;
        sts.scan_last = (CNT_W'(addr_reg) + CNT_W'(2)) == n_reg;
        sts.lerp      = lerp_reg;
        sts.axis_last = axis_reg == 2'd2;
        sts.out_free  = !m_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

[hw/rtl/tppi_ctrl.sv]
// Controller state machine sequencing append, timestamp pass and query.
`default_nettype none
module tppi_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire tppi_pkg::tppi_sts_t  sts,
    output tppi_pkg::tppi_cmd_t       cmd
);
    import tppi_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_SQ_RD     = 5'd2;
    localparam logic [4:0] S_SQ_DIFF   = 5'd3;
    localparam logic [4:0] S_SQ_MUL    = 5'd4;
    localparam logic [4:0] S_SQ_ACC    = 5'd5;
    localparam logic [4:0] S_SQRT      = 5'd6;
    localparam logic [4:0] S_SQRT_WAIT = 5'd7;
    localparam logic [4:0] S_APP_FIN   = 5'd8;
    localparam logic [4:0] S_TS_INIT   = 5'd9;
    localparam logic [4:0] S_TS_RD     = 5'd10;
    localparam logic [4:0] S_TS_CUM    = 5'd11;
    localparam logic [4:0] S_TS_DIV    = 5'd12;
    localparam logic [4:0] S_TS_WR     = 5'd13;
    localparam logic [4:0] S_Q_INIT    = 5'd14;
    localparam logic [4:0] S_Q_RD      = 5'd15;
    localparam logic [4:0] S_Q_CHK     = 5'd16;
    localparam logic [4:0] S_Q_A       = 5'd17;
    localparam logic [4:0] S_Q_ARD     = 5'd18;
    localparam logic [4:0] S_Q_ALAT    = 5'd19;
    localparam logic [4:0] S_Q_BRD     = 5'd20;
    localparam logic [4:0] S_Q_BLAT    = 5'd21;
    localparam logic [4:0] S_Q_CALC    = 5'd22;
    localparam logic [4:0] S_Q_SEL     = 5'd23;
    localparam logic [4:0] S_L_START   = 5'd24;
    localparam logic [4:0] S_L_WAIT    = 5'd25;
    localparam logic [4:0] S_L_STORE   = 5'd26;
    localparam logic [4:0] S_OUT       = 5'd27;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       reply_reg;
    logic       reply_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        reply_next = reply_reg;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_load = 1'b1;
                    reply_next   = 1'b0;
                    state_next   = sts.n_zero ? S_IDLE : S_TS_INIT;
                end else if (s_valid) begin
                    cmd.item_load = 1'b1;
                    reply_next    = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.exec_time = 1'b1;
                if (sts.op == OP_APPEND && !sts.full) begin
                    cmd.node_wr   = 1'b1;
                    cmd.addr_prev = 1'b1;
                    state_next    = sts.n_zero ? S_APP_FIN : S_SQ_RD;
                end else begin
                    state_next = S_Q_INIT;
                end
            end
            S_SQ_RD: begin
                state_next = S_SQ_DIFF;
            end
            S_SQ_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                cmd.sq_mul = 1'b1;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                cmd.sq_acc = 1'b1;
                state_next = sts.sq_last ? S_SQRT : S_SQ_MUL;
            end
            S_SQRT: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (sts.sqrt_done) begin
                    state_next = S_APP_FIN;
                end
            end
            S_APP_FIN: begin
                cmd.seg_commit = 1'b1;
                state_next     = S_TS_INIT;
            end
            S_TS_INIT: begin
                cmd.ts_init = 1'b1;
                state_next  = S_TS_RD;
            end
            S_TS_RD: begin
                state_next = S_TS_CUM;
            end
            S_TS_CUM: begin
                cmd.ts_cum = 1'b1;
                state_next = sts.pl_zero ? S_TS_WR : S_TS_DIV;
            end
            S_TS_DIV: begin
                if (sts.md_done) begin
                    state_next = S_TS_WR;
                end
            end
            S_TS_WR: begin
                cmd.ts_write = 1'b1;
                if (sts.ts_last) begin
                    state_next = reply_reg ? S_Q_INIT : S_IDLE;
                end else begin
                    state_next = S_TS_RD;
                end
            end
            S_Q_INIT: begin
                cmd.q_init = 1'b1;
                if (sts.n_zero) begin
                    state_next = S_OUT;
                end else if (sts.n_one) begin
                    state_next = S_Q_A;
                end else begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD: begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK: begin
                cmd.q_check = 1'b1;
                state_next  = sts.scan_last ? S_Q_A : S_Q_RD;
            end
            S_Q_A: begin
                cmd.addr_seg = 1'b1;
                state_next   = S_Q_ARD;
            end
            S_Q_ARD: begin
                state_next = S_Q_ALAT;
            end
            S_Q_ALAT: begin
                cmd.lat_a  = 1'b1;
                state_next = sts.n_one ? S_OUT : S_Q_BRD;
            end
            S_Q_BRD: begin
                state_next = S_Q_BLAT;
            end
            S_Q_BLAT: begin
                cmd.lat_b  = 1'b1;
                state_next = S_Q_CALC;
            end
            S_Q_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_Q_SEL;
            end
            S_Q_SEL: begin
                state_next = sts.lerp ? S_L_START : S_OUT;
            end
            S_L_START: begin
                cmd.lerp_start = 1'b1;
                state_next     = S_L_WAIT;
            end
            S_L_WAIT: begin
                if (sts.md_done) begin
                    state_next = S_L_STORE;
                end
            end
            S_L_STORE: begin
                cmd.lerp_store = 1'b1;
                state_next     = sts.axis_last ? S_OUT : S_L_START;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/timed_polyline_path_interpolator.sv]
// Top level: timed polyline path interpolator.
// Time ops scan the N stored nodes and, when the position falls between nodes, run three
// serial mul-divides, one per axis.
// An append adds a square root and then a timestamp pass that runs each node through the
// shared serial mul-divide; a config write runs that pass when nodes are stored, no result.
// One word in flight; the result register lets the next word enter while one waits.
// Reset (aresetn, synchronous): empty table, zero length, time and duration.
`default_nettype none
module timed_polyline_path_interpolator #(
    parameter int MAX_NODES = tppi_pkg::MAX_NODES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire tppi_pkg::tppi_in_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output tppi_pkg::tppi_out_t               m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tppi_pkg::TIME_W-1:0]  cfg_data
);
    import tppi_pkg::*;

    tppi_cmd_t cmd;
    tppi_sts_t sts;

    tppi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tppi_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && cfg_valid && cfg_ready))
        else $error("word and config accepted together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !cfg_ready))
        else $error("new word taken while one is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_EMPTY) |-> (m_data.node_total == '0))
        else $error("empty status with nodes stored");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the timed polyline path interpolator.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tppi_pkg::*;

    localparam int NODES = MAX_NODES_DEF;
    localparam int CFG_SETTLE = 3000;
    localparam int PHASE_WORDS = 300;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    tppi_in_t s_data;
    tppi_out_t m_data;
    logic [TIME_W-1:0] cfg_data;

    timed_polyline_path_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // path model state
    logic signed [COORD_W-1:0] node_x[NODES], node_y[NODES], node_z[NODES];
    logic [TIME_W-1:0] node_dwell[NODES], node_ts[NODES];
    logic [SEG_W-1:0] node_len[NODES];
    int node_cnt = 0;
    logic [ACC_W-1:0] path_len = '0;
    logic [TIME_W-1:0] now_t = '0, path_dur = '0;
    bit dwell_over = 1'b0;

    tppi_out_t fix_q[$];
    tppi_out_t fix_want;
    int mismatches = 0;
    int burst_left = 0;

    typedef struct {
        bit wr_dur;
        logic [TIME_W-1:0] dur_val;
        tppi_in_t word;
        bit typed;
        tppi_out_t want;
    } stim_row_t;
    stim_row_t rows[$];

    function automatic logic [31:0] absd(logic signed [31:0] a, logic signed [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [SEG_W-1:0] isqrt68(logic [67:0] v);
        logic [67:0] r, c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (68'd1 << b);
            if (c * c <= v) r = c;
        end
        return r[SEG_W-1:0];
    endfunction

    function automatic void rebuild_path();
        logic [67:0] sq;
        logic [31:0] d;
        longint unsigned dsum, dwell_acc;
        logic [ACC_W-1:0] cum;
        logic [TIME_W-1:0] travel;
        logic [78:0] prod;
        logic [63:0] ts;
        if (node_cnt == 0) return;
        path_len = '0;
        node_len[0] = '0;
        for (int i = 1; i < node_cnt; i++) begin
            d = absd(node_x[i], node_x[i-1]);
            sq = 68'(d) * 68'(d);
            d = absd(node_y[i], node_y[i-1]);
            sq = sq + 68'(d) * 68'(d);
            d = absd(node_z[i], node_z[i-1]);
            sq = sq + 68'(d) * 68'(d);
            node_len[i] = isqrt68(sq);
            path_len = path_len + node_len[i];
        end
        dsum = 0;
        for (int i = 0; i < node_cnt; i++) dsum += node_dwell[i];
        dwell_over = dsum > path_dur;
        travel = dwell_over ? '0 : TIME_W'(path_dur - dsum);
        cum = '0;
        dwell_acc = 0;
        for (int i = 0; i < node_cnt; i++) begin
            cum = cum + node_len[i];
            ts = 0;
            if (path_len != 0) begin
                prod = 79'(travel) * 79'(cum);
                ts = 64'(prod / 79'(path_len));
            end
            ts = ts + dwell_acc;
            node_ts[i] = (ts > TIME_MAX) ? TIME_MAX : ts[TIME_W-1:0];
            dwell_acc += node_dwell[i];
        end
    endfunction

    function automatic logic signed [31:0] lerp32(logic signed [31:0] a, logic signed [31:0] b,
                                                  longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint r;
        q = absd(b, a);
        q = q * num / den;
        r = (b >= a) ? longint'(a) + longint'(q) : longint'(a) - longint'(q);
        return r[31:0];
    endfunction

    function automatic tppi_out_t predict_fix(tppi_in_t w);
        tppi_out_t r;
        logic [2:0] rej;
        int seg;
        longint unsigned off, num;
        longint den;
        r = '0;
        rej = ST_OK;
        case (w.operation)
            OP_APPEND: begin
                if (node_cnt >= NODES) begin
                    rej = ST_FULL;
                end else begin
                    node_x[node_cnt] = w.point_x;
                    node_y[node_cnt] = w.point_y;
                    node_z[node_cnt] = w.point_z;
                    node_dwell[node_cnt] = w.dwell_delay;
                    node_cnt++;
                    rebuild_path();
                end
            end
            OP_SET: begin
                if (w.time_value > path_dur) rej = ST_TIME;
                else now_t = w.time_value;
            end
            OP_ADD: begin
                if ({1'b0, now_t} + {1'b0, w.time_value} <= {1'b0, path_dur})
                    now_t = now_t + w.time_value;
            end
            default: ;
        endcase
        if (rej != ST_OK) r.status = rej;
        else if (node_cnt == 0) r.status = ST_EMPTY;
        else if (dwell_over) r.status = ST_DWELL;
        else r.status = ST_OK;
        seg = 0;
        if (node_cnt == 1) begin
            r.pos_x = node_x[0]; r.pos_y = node_y[0]; r.pos_z = node_z[0];
            r.target_x = node_x[0]; r.target_y = node_y[0]; r.target_z = node_z[0];
        end else if (node_cnt >= 2) begin
            for (int i = 0; i + 1 < node_cnt; i++)
                if (node_ts[i] <= now_t) seg = i;
            r.target_x = node_x[seg+1]; r.target_y = node_y[seg+1]; r.target_z = node_z[seg+1];
            off = (now_t >= node_ts[seg]) ? now_t - node_ts[seg] : 0;
            if (off < node_dwell[seg]) begin
                r.pos_x = node_x[seg]; r.pos_y = node_y[seg]; r.pos_z = node_z[seg];
            end else begin
                den = longint'(node_ts[seg+1]) - longint'(node_ts[seg])
                      - longint'(node_dwell[seg]);
                num = off - node_dwell[seg];
                if (den <= 0 || num >= den) begin
                    r.pos_x = r.target_x; r.pos_y = r.target_y; r.pos_z = r.target_z;
                end else begin
                    r.pos_x = lerp32(node_x[seg], r.target_x, num, den);
                    r.pos_y = lerp32(node_y[seg], r.target_y, num, den);
                    r.pos_z = lerp32(node_z[seg], r.target_z, num, den);
                end
            end
        end
        r.segment_index = seg[SIDX_W-1:0];
        r.current_time = now_t;
        r.node_total = node_cnt[TOT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // receiver: stall pattern switches at random among its three modes
    int rx_mode = 0, rx_left = 0;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        m_ready <= (rx_mode == 0) || (rx_mode == 1 && $urandom_range(0, 1) == 1)
                   || (rx_mode == 2 && $urandom_range(0, 5) == 0);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fix_q.size() == 0) begin
                flag_mismatch("unexpected word", m_data.node_total, 0);
            end else begin
                fix_want = fix_q.pop_front();
                if (m_data.status !== fix_want.status)
                    flag_mismatch("status", m_data.status, fix_want.status);
                if (m_data.pos_x !== fix_want.pos_x)
                    flag_mismatch("pos_x", m_data.pos_x, fix_want.pos_x);
                if (m_data.pos_y !== fix_want.pos_y)
                    flag_mismatch("pos_y", m_data.pos_y, fix_want.pos_y);
                if (m_data.pos_z !== fix_want.pos_z)
                    flag_mismatch("pos_z", m_data.pos_z, fix_want.pos_z);
                if (m_data.target_x !== fix_want.target_x)
                    flag_mismatch("target_x", m_data.target_x, fix_want.target_x);
                if (m_data.target_y !== fix_want.target_y)
                    flag_mismatch("target_y", m_data.target_y, fix_want.target_y);
                if (m_data.target_z !== fix_want.target_z)
                    flag_mismatch("target_z", m_data.target_z, fix_want.target_z);
                if (m_data.segment_index !== fix_want.segment_index)
                    flag_mismatch("segment_index", m_data.segment_index,
                                  fix_want.segment_index);
                if (m_data.current_time !== fix_want.current_time)
                    flag_mismatch("current_time", m_data.current_time, fix_want.current_time);
                if (m_data.node_total !== fix_want.node_total)
                    flag_mismatch("node_total", m_data.node_total, fix_want.node_total);
            end
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (fix_q.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic set_duration(logic [TIME_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        path_dur = v;
        rebuild_path();
    endtask

    task automatic send_word(tppi_in_t w, bit typed, tppi_out_t want);
        tppi_out_t got;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        got = predict_fix(w);
        fix_q = {fix_q, (typed ? want : got)};
    endtask

    function automatic tppi_in_t mk_word(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [30:0] dw, logic [30:0] tv);
        tppi_in_t w;
        w.operation = op;
        w.point_x = x; w.point_y = y; w.point_z = z;
        w.dwell_delay = dw;
        w.time_value = tv;
        return w;
    endfunction

    function automatic tppi_out_t blank_fix(logic [2:0] st);
        tppi_out_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    task automatic add_row(bit wr, logic [30:0] dv, tppi_in_t w, bit typed, tppi_out_t want);
        stim_row_t r;
        r.wr_dur = wr; r.dur_val = dv; r.word = w; r.typed = typed; r.want = want;
        rows = {rows, r};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic tppi_in_t rand_word(bit may_append);
        tppi_in_t w;
        int k;
        w = mk_word(OP_NOP, rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 200), $urandom);
        k = $urandom_range(0, 99);
        if (k < 25 && may_append) begin
            w.operation = OP_APPEND;
        end else if (k < 60) begin
            w.operation = OP_SET;
            if ($urandom_range(0, 9) != 0) w.time_value = $urandom_range(0, path_dur);
        end else if (k < 92) begin
            w.operation = OP_ADD;
            if ($urandom_range(0, 9) != 0) w.time_value = $urandom_range(0, path_dur / 4 + 1);
        end
        if ($urandom_range(0, 19) == 0) w.dwell_delay = $urandom;
        if (w.operation == OP_APPEND && w.dwell_delay > 200) w.dwell_delay = 200;
        return w;
    endfunction

    logic [TIME_W-1:0] phase_dur;

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_ready = 1'b0;

        add_row(0, 0, mk_word(OP_NOP, 0, 0, 0, 0, 0), 1, blank_fix(ST_EMPTY));
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 0), 1, blank_fix(ST_EMPTY));
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, TIME_MAX), 1, blank_fix(ST_TIME));
        add_row(0, 0, mk_word(OP_ADD, 0, 0, 0, 0, 5), 1, blank_fix(ST_EMPTY));
        add_row(1, 1000, mk_word(OP_APPEND, 0, 0, 0, 10, 0), 0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 500), 0, '0);
        add_row(0, 0, mk_word(OP_APPEND, 0, 0, 0, 0, 0), 0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 100), 0, '0);
        add_row(0, 0, mk_word(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, -1, 0, 0), 0, '0);
        add_row(0, 0, mk_word(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 5, 0),
                0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 0), 0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 5), 0, '0);
        add_row(0, 0, mk_word(OP_ADD, 0, 0, 0, 0, 300), 0, '0);
        add_row(0, 0, mk_word(OP_ADD, 0, 0, 0, 0, 2000), 0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 1000), 0, '0);
        add_row(0, 0, mk_word(OP_SET, 0, 0, 0, 0, 1001), 0, '0);
        add_row(0, 0, mk_word(OP_NOP, 0, 0, 0, 0, 0), 0, '0);
        add_row(1, 10, mk_word(OP_SET, 0, 0, 0, 0, 3), 0, '0);
        add_row(0, 0, mk_word(OP_NOP, 0, 0, 0, 0, 0), 0, '0);
        add_row(1, TIME_MAX, mk_word(OP_SET, 0, 0, 0, 0, TIME_MAX), 0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        set_duration('0);

        foreach (rows[i]) begin
            if (rows[i].wr_dur) set_duration(rows[i].dur_val);
            send_word(rows[i].word, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: phase_dur = TIME_MAX;
                1: phase_dur = $urandom_range(100000, 32'h4000_0000);
                2: phase_dur = 20000;
                3: phase_dur = 3000;
                4: phase_dur = $urandom;
                default: phase_dur = 1000000;
            endcase
            set_duration(phase_dur);
            repeat (PHASE_WORDS) send_word(rand_word(node_cnt < NODES - 1), 0, '0);
        end

        // last node carries a dwell no duration can cover, then the table is full
        set_duration(TIME_MAX);
        send_word(mk_word(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), TIME_MAX, 0),
                  0, '0);
        repeat (100) send_word(rand_word(1'b1), 0, '0);

        s_valid <= 1'b0;
        while (fix_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS timed_polyline_path_interpolator");
        end else begin
            $display("FAIL timed_polyline_path_interpolator");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAIL timed_polyline_path_interpolator");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
hw/rtl/tppi_pkg.sv
hw/rtl/tppi_ram.sv
hw/rtl/tppi_sqrt.sv
hw/rtl/tppi_muldiv.sv
hw/rtl/tppi_datapath.sv
hw/rtl/tppi_ctrl.sv
hw/rtl/timed_polyline_path_interpolator.sv
sim/tb_top.sv
